FILE: design/one_wire_bus_master_unit_assert.svh
// Assertion macros for the one-wire bus master unit.
`ifndef ONE_WIRE_BUS_MASTER_UNIT_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked only while out of reset.
`define OWBM_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("one-wire master assertion failed");
// Checked at every edge, reset included.
`define OWBM_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("one-wire master assertion failed");
`else
`define OWBM_ASSERT(label, prop)
`define OWBM_ASSERT_ALWAYS(label, prop)
`endif

`endif

FILE: design/owbm_pkg.sv
// Shared types and constants of the one-wire bus master unit.
package owbm_pkg;

    // Default width of the microsecond counter
    localparam int COUNTER_BITS_DEF = 10;

    // Operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [2:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [2:0] CFG_RESET_TAIL    = 3'd2;
    localparam logic [2:0] CFG_WRITE_ONE_LOW = 3'd3;
    localparam logic [2:0] CFG_SLOT          = 3'd4;
    localparam logic [2:0] CFG_READ_LOW      = 3'd5;
    localparam logic [2:0] CFG_RECOVERY      = 3'd6;

    // Configuration register defaults
    localparam logic [9:0] RESET_LOW_DEF     = 10'd480;
    localparam logic [9:0] PRESENCE_WAIT_DEF = 10'd80;
    localparam logic [9:0] RESET_TAIL_DEF    = 10'd400;
    localparam logic [3:0] WRITE_ONE_LOW_DEF = 4'd1;
    localparam logic [9:0] SLOT_DEF          = 10'd60;
    localparam logic [3:0] READ_LOW_DEF      = 4'd2;
    localparam logic [5:0] RECOVERY_DEF      = 6'd1;

    // Bus sequencer phases
    typedef enum logic [6:0] {
        PH_IDLE     = 7'b0000001,
        PH_RST_LOW  = 7'b0000010,
        PH_RST_WAIT = 7'b0000100,
        PH_RST_TAIL = 7'b0001000,
        PH_BIT_LOW  = 7'b0010000,
        PH_BIT_REL  = 7'b0100000,
        PH_RECOV    = 7'b1000000
    } phase_t;

endpackage

FILE: design/one_wire_bus_master_unit.sv
// One-wire bus master: one microsecond tick per item, one result item per tick.
// Latency: the result item of an input item is valid in the cycle after it is accepted.
// Throughput: one item per cycle while m_ready is high; the phase/counter update is a single registered pass.
// A waiting result holds off the input; with m_ready high the next item is taken as it leaves.
// Reset (aresetn low, synchronous) returns the sequencer to idle, clears the counter,
// presence flag and read byte, and loads the configuration registers with their defaults.
`include "one_wire_bus_master_unit_assert.svh"

module one_wire_bus_master_unit #(
    parameter int COUNTER_BITS = owbm_pkg::COUNTER_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration write port
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [9:0] cfg_wdata,
    // tick input
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_operation,
    input  logic [7:0] s_tx_byte,
    input  logic       s_line_level,
    // result output
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_pull_low,
    output logic       m_busy_res,
    output logic       m_done_res,
    output logic       m_device_present,
    output logic [7:0] m_rx_byte
);
    import owbm_pkg::*;

    // Compare width covers both the counter and the widest length register
    localparam int CMP_W = (COUNTER_BITS > 10) ? COUNTER_BITS : 10;
    localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'((64'd1 << COUNTER_BITS) - 64'd1);

    // Lengths above the counter range clamp to its maximum
    function automatic logic [CMP_W-1:0] lim_len(input logic [CMP_W-1:0] len);
        return (len > CNT_MAX) ? CNT_MAX : len;
    endfunction

    // Configuration registers
    logic [9:0] reset_low_reg, presence_wait_reg, reset_tail_reg, slot_reg;
    logic [3:0] write_one_low_reg, read_low_reg;
    logic [5:0] recovery_reg;

    // Sequencer state
    phase_t                  phase_reg, phase_next;
    logic [COUNTER_BITS-1:0] us_counter_reg, us_counter_next;
    logic [2:0]              bit_index_reg, bit_index_next;
    logic [7:0]              shift_byte_reg, shift_byte_next;
    logic [1:0]              op_kind_reg, op_kind_next;
    logic                    presence_reg, presence_next;
    logic [7:0]              rx_hold_reg, rx_hold_next;

    // Output register
    logic       m_valid_reg, m_valid_next;
    logic       pull_low_reg, busy_reg, done_reg;
    logic       pull_low_next, done_next;

    logic in_accept;

    // State after a possible command start on this tick
    logic                    start;
    phase_t                  ph_s;
    logic [COUNTER_BITS-1:0] cnt_s, cnt_inc;
    logic [2:0]              bidx_s;
    logic [7:0]              shf_s;
    logic [1:0]              opk_s;
    logic [CMP_W-1:0]        inc_ext, bit_len;
    logic                    zero_bit;

    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;

    // Command start: only taken while idle
    assign start   = (phase_reg == PH_IDLE) && (s_operation != OP_TICK);
    assign ph_s    = start ? ((s_operation == OP_RESET) ? PH_RST_LOW : PH_BIT_LOW) : phase_reg;
    assign cnt_s   = start ? '0 : us_counter_reg;
    assign bidx_s  = start ? 3'd0 : bit_index_reg;
    assign opk_s   = start ? s_operation : op_kind_reg;
    assign shf_s   = start ? ((s_operation == OP_WRITE) ? s_tx_byte : 8'd0) : shift_byte_reg;

    assign cnt_inc = cnt_s + COUNTER_BITS'(1);
    assign inc_ext = CMP_W'(cnt_inc);

    // Low time of the current bit slot
    assign zero_bit = (opk_s == OP_WRITE) && !shf_s[0];
    always_comb begin
        if (opk_s == OP_READ) begin
            bit_len = CMP_W'(read_low_reg);
        end else if (zero_bit) begin
            bit_len = CMP_W'(slot_reg);
        end else begin
            bit_len = CMP_W'(write_one_low_reg);
        end
    end

    // Phase sequencer: one microsecond per accepted item
    always_comb begin
        logic finish_op;
        logic end_bit;
        phase_next      = ph_s;
        us_counter_next = cnt_s;
        bit_index_next  = bidx_s;
        shift_byte_next = shf_s;
        op_kind_next    = opk_s;
        presence_next   = presence_reg;
        rx_hold_next    = rx_hold_reg;
        pull_low_next   = 1'b0;
        finish_op       = 1'b0;
        end_bit         = 1'b0;

        unique case (ph_s)
            PH_RST_LOW: begin
                pull_low_next   = 1'b1;
                us_counter_next = cnt_inc;
                if (inc_ext >= lim_len(CMP_W'(reset_low_reg))) begin
                    phase_next      = PH_RST_WAIT;
                    us_counter_next = '0;
                end
            end
            PH_RST_WAIT: begin
                if (CMP_W'(cnt_s) >= lim_len(CMP_W'(presence_wait_reg))) begin
                    presence_next   = !s_line_level;
                    phase_next      = PH_RST_TAIL;
                    us_counter_next = '0;
                    finish_op       = (reset_tail_reg == 10'd0);
                end else begin
                    us_counter_next = cnt_inc;
                end
            end
            PH_RST_TAIL: begin
                us_counter_next = cnt_inc;
                finish_op       = (inc_ext >= lim_len(CMP_W'(reset_tail_reg)));
            end
            PH_BIT_LOW: begin
                pull_low_next   = 1'b1;
                us_counter_next = cnt_inc;
                if (inc_ext >= lim_len(bit_len)) begin
                    us_counter_next = '0;
                    if (!zero_bit) begin
                        phase_next = PH_BIT_REL;
                    end else if (recovery_reg == 6'd0) begin
                        end_bit = 1'b1;
                    end else begin
                        phase_next = PH_RECOV;
                    end
                end
            end
            PH_BIT_REL: begin
                // read sample on the first released tick
                if (opk_s == OP_READ && cnt_s == '0) begin
                    shift_byte_next = {s_line_level, shf_s[7:1]};
                end
                us_counter_next = cnt_inc;
                end_bit         = (inc_ext >= lim_len(CMP_W'(slot_reg)));
            end
            PH_RECOV: begin
                us_counter_next = cnt_inc;
                end_bit         = (inc_ext >= lim_len(CMP_W'(recovery_reg)));
            end
            default: begin
                phase_next      = PH_IDLE;
                us_counter_next = '0;
            end
        endcase

        // Bit end: next bit or finish the byte
        if (end_bit) begin
            if (opk_s == OP_WRITE) begin
                shift_byte_next = {1'b0, shift_byte_next[7:1]};
            end
            if (bidx_s == 3'd7) begin
                finish_op = 1'b1;
            end else begin
                bit_index_next  = bidx_s + 3'd1;
                phase_next      = PH_BIT_LOW;
                us_counter_next = '0;
            end
        end

        if (finish_op) begin
            if (opk_s == OP_READ) begin
                rx_hold_next = shift_byte_next;
            end
            phase_next      = PH_IDLE;
            us_counter_next = '0;
        end
        done_next = finish_op;
    end

    assign m_valid_next = in_accept ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reset_low_reg     <= RESET_LOW_DEF;
            presence_wait_reg <= PRESENCE_WAIT_DEF;
            reset_tail_reg    <= RESET_TAIL_DEF;
            write_one_low_reg <= WRITE_ONE_LOW_DEF;
            slot_reg          <= SLOT_DEF;
            read_low_reg      <= READ_LOW_DEF;
            recovery_reg      <= RECOVERY_DEF;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_RESET_LOW:     reset_low_reg     <= cfg_wdata;
                CFG_PRESENCE_WAIT: presence_wait_reg <= cfg_wdata;
                CFG_RESET_TAIL:    reset_tail_reg    <= cfg_wdata;
                CFG_WRITE_ONE_LOW: write_one_low_reg <= cfg_wdata[3:0];
                CFG_SLOT:          slot_reg          <= cfg_wdata;
                CFG_READ_LOW:      read_low_reg      <= cfg_wdata[3:0];
                CFG_RECOVERY:      recovery_reg      <= cfg_wdata[5:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            us_counter_reg <= '0;
            bit_index_reg  <= 3'd0;
            shift_byte_reg <= 8'd0;
            op_kind_reg    <= OP_TICK;
            presence_reg   <= 1'b0;
            rx_hold_reg    <= 8'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (in_accept) begin
                phase_reg      <= phase_next;
                us_counter_reg <= us_counter_next;
                bit_index_reg  <= bit_index_next;
                shift_byte_reg <= shift_byte_next;
                op_kind_reg    <= op_kind_next;
                presence_reg   <= presence_next;
                rx_hold_reg    <= rx_hold_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            pull_low_reg <= pull_low_next;
            busy_reg     <= (phase_next != PH_IDLE);
            done_reg     <= done_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_pull_low       = pull_low_reg;
    assign m_busy_res       = busy_reg;
    assign m_done_res       = done_reg;
    assign m_device_present = presence_reg;
    assign m_rx_byte        = rx_hold_reg;

    // Checks
    `OWBM_ASSERT_ALWAYS(a_reset_clears_valid, !aresetn |=> !m_valid_reg)
    `OWBM_ASSERT(a_accept_gives_result, in_accept |=> m_valid_reg)
    `OWBM_ASSERT(a_done_not_busy, (m_valid_reg && done_reg) |-> !busy_reg)
    `OWBM_ASSERT(a_drive_while_active, (m_valid_reg && pull_low_reg) |-> (busy_reg || done_reg))
    `OWBM_ASSERT(a_idle_counter_clear, (phase_reg == PH_IDLE) |-> (us_counter_reg == '0))

endmodule

FILE: test/one_wire_bus_master_unit_checker.sv
// Checker for the one-wire bus master: predicts every result item and compares it.
module one_wire_bus_master_unit_checker #(
    parameter int COUNTER_BITS = owbm_pkg::COUNTER_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [9:0] cfg_wdata,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [1:0] s_operation,
    input  logic [7:0] s_tx_byte,
    input  logic       s_line_level,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_pull_low,
    input  logic       m_busy_res,
    input  logic       m_done_res,
    input  logic       m_device_present,
    input  logic [7:0] m_rx_byte,
    output logic       seq_idle,
    output int         pending_results,
    output int         ticks_checked,
    output int         ops_started,
    output int         fail_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import owbm_pkg::*;

    localparam int CNT_MAX = (1 << COUNTER_BITS) - 1;

    typedef struct packed {
        logic       pull_low;
        logic       busy;
        logic       done;
        logic       present;
        logic [7:0] rx_byte;
    } bus_result_t;

    // Timing registers as the block should hold them
    logic [9:0] reset_low_len, presence_wait_len, reset_tail_len, slot_len;
    logic [3:0] write_one_len, read_low_len;
    logic [5:0] recovery_len;

    // Predicted sequencer state
    phase_t                  seq_phase;
    logic [COUNTER_BITS-1:0] us_count;
    logic [2:0]              bit_pos;
    logic [7:0]              shift_reg;
    logic [1:0]              cur_op;
    logic                    presence;
    logic [7:0]              rx_hold;
    logic                    done_now;

    bus_result_t expected_ticks[$];

    // Lengths beyond the counter range saturate
    function automatic int clamp_len(input int len);
        return (len > CNT_MAX) ? CNT_MAX : len;
    endfunction

    function automatic logic count_reached(input int len);
        us_count = us_count + 1'b1;
        return int'(us_count) >= clamp_len(len);
    endfunction

    function automatic void finish_op();
        if (cur_op == OP_READ) begin
            rx_hold = shift_reg;
        end
        seq_phase = PH_IDLE;
        us_count  = '0;
        done_now  = 1'b1;
    endfunction

    // Close a bit slot; writes shift out LSB first
    function automatic void next_bit();
        if (cur_op == OP_WRITE) begin
            shift_reg = shift_reg >> 1;
        end
        if (bit_pos == 3'd7) begin
            finish_op();
        end else begin
            bit_pos   = bit_pos + 1'b1;
            seq_phase = PH_BIT_LOW;
            us_count  = '0;
        end
    endfunction

    // One microsecond of the bus sequencer
    function automatic bus_result_t bus_tick(input logic [1:0] op, input logic [7:0] tx,
                                             input logic line);
        bus_result_t r;
        logic        zero_bit;
        int          len;
        r        = '0;
        done_now = 1'b0;
        // A command only starts from idle; the start tick is already active
        if (seq_phase == PH_IDLE && op != OP_TICK) begin
            cur_op   = op;
            us_count = '0;
            bit_pos  = '0;
            ops_started++;
            if (op == OP_RESET) begin
                seq_phase = PH_RST_LOW;
            end else begin
                seq_phase = PH_BIT_LOW;
                shift_reg = (op == OP_WRITE) ? tx : 8'h00;
            end
        end
        case (seq_phase)
            PH_RST_LOW: begin
                r.pull_low = 1'b1;
                if (count_reached(int'(reset_low_len))) begin
                    seq_phase = PH_RST_WAIT;
                    us_count  = '0;
                end
            end
            PH_RST_WAIT: begin
                if (int'(us_count) >= clamp_len(int'(presence_wait_len))) begin
                    presence  = ~line;
                    seq_phase = PH_RST_TAIL;
                    us_count  = '0;
                    if (reset_tail_len == '0) begin
                        finish_op();
                    end
                end else begin
                    us_count = us_count + 1'b1;
                end
            end
            PH_RST_TAIL: begin
                if (count_reached(int'(reset_tail_len))) begin
                    finish_op();
                end
            end
            PH_BIT_LOW: begin
                zero_bit   = (cur_op == OP_WRITE) && !shift_reg[0];
                r.pull_low = 1'b1;
                if (cur_op == OP_READ) begin
                    len = int'(read_low_len);
                end else if (zero_bit) begin
                    len = int'(slot_len);
                end else begin
                    len = int'(write_one_len);
                end
                if (count_reached(len)) begin
                    us_count = '0;
                    if (zero_bit) begin
                        if (recovery_len == '0) begin
                            next_bit();
                        end else begin
                            seq_phase = PH_RECOV;
                        end
                    end else begin
                        seq_phase = PH_BIT_REL;
                    end
                end
            end
            PH_BIT_REL: begin
                // read samples on the first released tick
                if (cur_op == OP_READ && us_count == '0) begin
                    shift_reg = {line, shift_reg[7:1]};
                end
                if (count_reached(int'(slot_len))) begin
                    next_bit();
                end
            end
            PH_RECOV: begin
                if (count_reached(int'(recovery_len))) begin
                    next_bit();
                end
            end
            default: begin
                seq_phase = PH_IDLE;
                us_count  = '0;
            end
        endcase
        r.busy    = (seq_phase != PH_IDLE);
        r.done    = done_now;
        r.present = presence;
        r.rx_byte = rx_hold;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("ERROR: result %0d %s: got 0x%0h, expected 0x%0h",
                 ticks_checked, field, got, want);
        fail_count++;
    endtask

    // Watch config writes and both channels
    always @(posedge aclk) begin : monitor
        bus_result_t want;
        if (!aresetn) begin
            reset_low_len     = RESET_LOW_DEF;
            presence_wait_len = PRESENCE_WAIT_DEF;
            reset_tail_len    = RESET_TAIL_DEF;
            write_one_len     = WRITE_ONE_LOW_DEF;
            slot_len          = SLOT_DEF;
            read_low_len      = READ_LOW_DEF;
            recovery_len      = RECOVERY_DEF;
            seq_phase         = PH_IDLE;
            us_count          = '0;
            bit_pos           = '0;
            shift_reg         = '0;
            cur_op            = OP_TICK;
            presence          = 1'b0;
            rx_hold           = '0;
            done_now          = 1'b0;
            expected_ticks.delete();
            ticks_checked     = 0;
            ops_started       = 0;
            fail_count        = 0;
            seq_idle        <= 1'b1;
            pending_results <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_RESET_LOW:     reset_low_len     = cfg_wdata;
                    CFG_PRESENCE_WAIT: presence_wait_len = cfg_wdata;
                    CFG_RESET_TAIL:    reset_tail_len    = cfg_wdata;
                    CFG_WRITE_ONE_LOW: write_one_len     = cfg_wdata[3:0];
                    CFG_SLOT:          slot_len          = cfg_wdata;
                    CFG_READ_LOW:      read_low_len      = cfg_wdata[3:0];
                    CFG_RECOVERY:      recovery_len      = cfg_wdata[5:0];
                    default: ;
                endcase
            end
            // result items: oldest prediction first
            if (m_valid && m_ready) begin
                if (expected_ticks.size() == 0) begin
                    report_mismatch("result item with nothing pending", 1, 0);
                end else begin
                    want = expected_ticks.pop_front();
                    if (m_pull_low !== want.pull_low)
                        report_mismatch("pull_low", int'(m_pull_low), int'(want.pull_low));
                    if (m_busy_res !== want.busy)
                        report_mismatch("busy_res", int'(m_busy_res), int'(want.busy));
                    if (m_done_res !== want.done)
                        report_mismatch("done_res", int'(m_done_res), int'(want.done));
                    if (m_device_present !== want.present)
                        report_mismatch("device_present", int'(m_device_present),
                                        int'(want.present));
                    if (m_rx_byte !== want.rx_byte)
                        report_mismatch("rx_byte", int'(m_rx_byte), int'(want.rx_byte));
                    ticks_checked++;
                end
            end
            if (s_valid && s_ready) begin
                expected_ticks.push_back(bus_tick(s_operation, s_tx_byte, s_line_level));
            end
            seq_idle        <= (seq_phase == PH_IDLE);
            pending_results <= expected_ticks.size();
        end
    end

endmodule

FILE: test/one_wire_bus_master_unit_test.sv
// Testbench top for the one-wire bus master: clock, reset, stimulus and verdict.
module one_wire_bus_master_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import owbm_pkg::*;

    localparam int CYCLE_LIMIT  = 800_000;
    localparam int RANDOM_ITEMS = 360;
    localparam int IDLE_PCT     = 38;
    // line level drive modes
    localparam int LINE_LOW     = 0;
    localparam int LINE_HIGH    = 1;
    localparam int LINE_RANDOM  = 2;

    typedef struct {
        int reset_low;
        int presence_wait;
        int reset_tail;
        int write_one_low;
        int slot;
        int read_low;
        int recovery;
    } bus_timing_t;

    logic       aclk         = 1'b0;
    logic       aresetn      = 1'b0;
    logic       cfg_we       = 1'b0;
    logic [2:0] cfg_index    = '0;
    logic [9:0] cfg_wdata    = '0;
    logic       s_valid      = 1'b0;
    logic       s_ready;
    logic [1:0] s_operation  = OP_TICK;
    logic [7:0] s_tx_byte    = '0;
    logic       s_line_level = 1'b1;
    logic       m_valid;
    logic       m_ready      = 1'b0;
    logic       m_pull_low;
    logic       m_busy_res;
    logic       m_done_res;
    logic       m_device_present;
    logic [7:0] m_rx_byte;

    logic seq_idle;
    int   pending_results;
    int   ticks_checked;
    int   ops_started;
    int   fail_count;

    bit   idle_on      = 1'b1;
    int   items_sent   = 0;
    int   settings_run = 0;
    int   cycle_count  = 0;

    one_wire_bus_master_unit u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_tx_byte        (s_tx_byte),
        .s_line_level     (s_line_level),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pull_low       (m_pull_low),
        .m_busy_res       (m_busy_res),
        .m_done_res       (m_done_res),
        .m_device_present (m_device_present),
        .m_rx_byte        (m_rx_byte)
    );

    one_wire_bus_master_unit_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_tx_byte        (s_tx_byte),
        .s_line_level     (s_line_level),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pull_low       (m_pull_low),
        .m_busy_res       (m_busy_res),
        .m_done_res       (m_done_res),
        .m_device_present (m_device_present),
        .m_rx_byte        (m_rx_byte),
        .seq_idle         (seq_idle),
        .pending_results  (pending_results),
        .ticks_checked    (ticks_checked),
        .ops_started      (ops_started),
        .fail_count       (fail_count)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Result side stalls at random unless idling is switched off
    always @(posedge aclk) begin
        m_ready <= idle_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
    end

    // Hard stop
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped: cycle limit of %0d reached", CYCLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic pick_line(input int mode);
        case (mode)
            LINE_LOW:  return 1'b0;
            LINE_HIGH: return 1'b1;
            default:   return 1'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic bus_timing_t make_timing(input int rl, input int pw, input int rt,
                                                input int w1, input int sl, input int rd,
                                                input int rc);
        bus_timing_t t;
        t.reset_low     = rl;
        t.presence_wait = pw;
        t.reset_tail    = rt;
        t.write_one_low = w1;
        t.slot          = sl;
        t.read_low      = rd;
        t.recovery      = rc;
        return t;
    endfunction

    // Short timings keep many operations inside the item budget
    function automatic bus_timing_t random_timing();
        return make_timing($urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 4),
                           $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
                           $urandom_range(0, 3));
    endfunction

    // One tick item; valid holds until accepted, random idle cycles before it
    task automatic send_item(input logic [1:0] op, input logic [7:0] tx, input logic line);
        int gap;
        gap = 0;
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_tx_byte    <= tx;
        s_line_level <= line;
        do @(posedge aclk); while (!(s_valid && s_ready));
        items_sent++;
    endtask

    // Start a command and keep ticking until the sequencer is back to idle.
    // seq_idle seen after an accept reflects the item before it.
    task automatic run_op(input logic [1:0] op, input logic [7:0] tx, input int line_mode,
                          input bit busy_noise);
        send_item(op, tx, pick_line(line_mode));
        do begin
            if (busy_noise && $urandom_range(0, 11) == 0) begin
                send_item(2'($urandom_range(OP_RESET, OP_READ)), 8'($urandom_range(0, 255)),
                          pick_line(line_mode));
            end else begin
                send_item(OP_TICK, 8'($urandom_range(0, 255)), pick_line(line_mode));
            end
        end while (!seq_idle);
    endtask

    // Hold off the sender until every predicted result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
    endtask

    // Tick to idle, then drain; the block is quiet afterwards
    task automatic settle();
        do send_item(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        while (!seq_idle);
        wait_drained();
    endtask

    task automatic write_reg(input logic [2:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[9:0];
        @(posedge aclk);
    endtask

    task automatic load_timing(input bus_timing_t t);
        write_reg(CFG_RESET_LOW, t.reset_low);
        write_reg(CFG_PRESENCE_WAIT, t.presence_wait);
        write_reg(CFG_RESET_TAIL, t.reset_tail);
        write_reg(CFG_WRITE_ONE_LOW, t.write_one_low);
        write_reg(CFG_SLOT, t.slot);
        write_reg(CFG_READ_LOW, t.read_low);
        write_reg(CFG_RECOVERY, t.recovery);
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    // Field extremes, each operation, presence both ways, commands while busy
    task automatic directed_ops();
        send_item(OP_TICK, 8'hFF, 1'b0);
        send_item(OP_TICK, 8'h00, 1'b1);
        run_op(OP_RESET, 8'h00, LINE_LOW, 1'b0);
        run_op(OP_RESET, 8'hFF, LINE_HIGH, 1'b0);
        run_op(OP_WRITE, 8'h00, LINE_HIGH, 1'b0);
        run_op(OP_WRITE, 8'hFF, LINE_HIGH, 1'b0);
        run_op(OP_READ, 8'h00, LINE_HIGH, 1'b0);
        run_op(OP_READ, 8'hFF, LINE_LOW, 1'b0);
        // the read and reset land mid-write and must be ignored
        send_item(OP_WRITE, 8'h96, 1'b1);
        send_item(OP_READ, 8'h00, 1'b0);
        send_item(OP_RESET, 8'h00, 1'b0);
        settle();
    endtask

    // Mostly complete operations with random content, some loose noise
    task automatic random_traffic(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 80) begin
                run_op(2'($urandom_range(OP_RESET, OP_READ)), 8'($urandom_range(0, 255)),
                       LINE_RANDOM, 1'b1);
            end else begin
                repeat ($urandom_range(1, 5))
                    send_item(2'($urandom_range(OP_TICK, OP_READ)),
                              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 99) < 5) wait_drained();
        end
        settle();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // short timings, then all-zero lengths
        load_timing(make_timing(2, 1, 1, 2, 2, 1, 1));
        directed_ops();
        load_timing(make_timing(0, 0, 0, 0, 0, 0, 0));
        directed_ops();

        // smallest legal lengths
        load_timing(make_timing(1, 1, 0, 1, 1, 1, 0));
        random_traffic(80);

        // widest pulse and recovery fields: one operation of each kind
        load_timing(make_timing(12, 6, 5, 15, 2, 15, 63));
        run_op(OP_RESET, 8'h00, LINE_RANDOM, 1'b0);
        run_op(OP_WRITE, 8'h5A, LINE_HIGH, 1'b0);
        run_op(OP_READ, 8'h00, LINE_RANDOM, 1'b0);
        settle();

        // random short timings; the third set runs without any idling
        for (int k = 0; k < 4; k++) begin
            idle_on <= (k != 2);
            load_timing(random_timing());
            random_traffic(RANDOM_ITEMS / 4);
        end
        idle_on <= 1'b1;

        wait_drained();
        repeat (4) @(posedge aclk);
        $display("Checked %0d result items over %0d timing settings (%0d items sent).",
                 ticks_checked, settings_run, items_sent);
        $display("Bus operations started: %0d; zero, minimum, widest pulse and random timings.",
                 ops_started);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/owbm_pkg.sv
design/one_wire_bus_master_unit.sv
test/one_wire_bus_master_unit_checker.sv
test/one_wire_bus_master_unit_test.sv
